>>> hdl/crk_pkg.sv
`default_nettype none

package crk_pkg;

  localparam int MaxKeys = 64;
  localparam int IdxW    = $clog2(MaxKeys);
  localparam int CntW    = $clog2(MaxKeys + 1);
  localparam int TimeW   = 32;
  localparam int FieldW  = 32;
  localparam int ValW    = 32;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_READ   = 2'd1,
    KIND_CLEAR  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

  typedef struct packed {
    kind_e                     kind;
    logic signed [TimeW-1:0]   key_time;
    logic signed [FieldW-1:0]  value_x;
    logic signed [FieldW-1:0]  value_y;
    logic signed [FieldW-1:0]  value_z;
    logic        [IdxW-1:0]    read_index;
  } in_word_t;

  typedef struct packed {
    status_e                   status;
    logic        [IdxW-1:0]    position;
    logic signed [TimeW-1:0]   out_time;
    logic signed [FieldW-1:0]  out_x;
    logic signed [FieldW-1:0]  out_y;
    logic signed [FieldW-1:0]  out_z;
    logic signed [FieldW-1:0]  tangent_out_x;
    logic signed [FieldW-1:0]  tangent_out_y;
    logic signed [FieldW-1:0]  tangent_out_z;
    logic        [CntW-1:0]    key_count;
  } out_word_t;

  // what every cell shows its neighbors and the read bus
  typedef struct packed {
    logic                    valid;
    logic                    go;
    logic signed [TimeW-1:0] key_time;
    logic signed [ValW-1:0]  x;
    logic signed [ValW-1:0]  y;
    logic signed [ValW-1:0]  z;
    logic signed [ValW-1:0]  tx;
    logic signed [ValW-1:0]  ty;
    logic signed [ValW-1:0]  tz;
  } cell_t;

  // broadcast to all cells
  typedef struct packed {
    logic                    insert;
    logic                    clear;
    logic signed [TimeW-1:0] key_time;
    logic signed [ValW-1:0]  x;
    logic signed [ValW-1:0]  y;
    logic signed [ValW-1:0]  z;
  } ctrl_t;

  // floor of half the difference, formed one bit wider so it never wraps
  function automatic logic signed [ValW-1:0] half_diff(
    input logic signed [ValW-1:0] a,
    input logic signed [ValW-1:0] b
  );
    logic [ValW:0] d;
    d = {a[ValW-1], a} - {b[ValW-1], b};
    return d[ValW:1];
  endfunction

endpackage

`default_nettype wire

>>> hdl/crk_in_if.sv
`default_nettype none

interface crk_in_if import crk_pkg::*; ();
  logic     valid;
  logic     ready;
  in_word_t data;

  modport src (output valid, output data, input ready);
  modport snk (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> hdl/crk_out_if.sv
`default_nettype none

interface crk_out_if import crk_pkg::*; ();
  logic      valid;
  logic      ready;
  out_word_t data;

  modport src (output valid, output data, input ready);
  modport snk (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> hdl/catmull_rom_key_table.sv
// Sorted animation key table with Catmull-Rom tangents.
// in_i carries one word per command: insert a key (time, x, y, z), read the
// entry at read_index, or clear the table. out_o returns exactly one word per
// command with status, position, the read entry and its tangent, and the key
// count after the command.
// Keys sit in a row of cells in time order; an insert compares all cells at
// once and shifts the later ones up by one cell in the same cycle. Each cell
// refreshes its tangent register from its neighbors every cycle.
// The result word is registered and appears in the cycle after acceptance.
// Throughput: one command per cycle while out_o is ready, except that
// in_i.ready is low after each insert while the cell tangents settle.
// A stalled receiver holds the result register; a new command is taken in
// the cycle the pending word leaves, or whenever the register is empty, but not while tangents settle.
// Reset empties the table (key count zero) and drops any pending result;
// the block is ready in the first cycle after reset.
`default_nettype none

module catmull_rom_key_table import crk_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  crk_in_if.snk         in_i,
  crk_out_if.src        out_o
);

  localparam cell_t EdgeCell = '{valid: 1'b0, go: 1'b1, default: '0};

  cell_t            cells  [MaxKeys];
  cell_t            prev_c [MaxKeys];
  cell_t            next_c [MaxKeys];
  logic [MaxKeys-1:0] valid_vec;

  ctrl_t            ctrl;
  logic [CntW-1:0]  count_q, count_d;
  logic             settle_q;
  logic             out_valid_q;
  out_word_t        out_word_q, res;
  logic             in_acc, full, in_range;
  logic [IdxW-1:0]  ins_pos;
  cell_t            rd;

  assign in_acc = in_i.valid && in_i.ready;
  assign full   = count_q == CntW'(MaxKeys);

  assign ctrl.insert   = in_acc && (in_i.data.kind == KIND_INSERT) && !full;
  assign ctrl.clear    = in_acc && (in_i.data.kind == KIND_CLEAR);
  assign ctrl.key_time = in_i.data.key_time;
  assign ctrl.x        = ValW'(in_i.data.value_x);
  assign ctrl.y        = ValW'(in_i.data.value_y);
  assign ctrl.z        = ValW'(in_i.data.value_z);

  for (genvar i = 0; i < MaxKeys; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign prev_c[i] = EdgeCell;
    end else begin : g_mid
      assign prev_c[i] = cells[i-1];
    end
    if (i == MaxKeys - 1) begin : g_last
      assign next_c[i] = '0;
    end else begin : g_inner
      assign next_c[i] = cells[i+1];
    end
    assign valid_vec[i] = cells[i].valid;

    crk_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl),
      .prev_i (prev_c[i]),
      .next_i (next_c[i]),
      .cell_o (cells[i])
    );
  end

  // first cell that gives way takes the new key
  always_comb begin
    ins_pos = '0;
    for (int i = 0; i < MaxKeys; i++) begin
      if (prev_c[i].go && !cells[i].go) begin
        ins_pos = ins_pos | IdxW'(i);
      end
    end
  end

  always_comb begin
    rd = '0;
    for (int i = 0; i < MaxKeys; i++) begin
      if (IdxW'(i) == in_i.data.read_index) begin
        rd = cells[i];
      end
    end
  end

  assign in_range = {1'b0, in_i.data.read_index} < count_q;

  always_comb begin
    count_d = count_q;
    if (ctrl.clear) begin
      count_d = '0;
    end else if (ctrl.insert) begin
      count_d = count_q + 1'b1;
    end
  end

  always_comb begin
    res           = '0;
    res.key_count = count_d;
    case (in_i.data.kind)
      KIND_INSERT: begin
        if (full) begin
          res.status = ST_FULL;
        end else begin
          res.position = ins_pos;
        end
      end
      KIND_READ: begin
        res.position = in_i.data.read_index;
        if (!in_range) begin
          res.status = ST_RANGE;
        end else begin
          res.out_time      = rd.key_time;
          res.out_x         = FieldW'(rd.x);
          res.out_y         = FieldW'(rd.y);
          res.out_z         = FieldW'(rd.z);
          res.tangent_out_x = FieldW'(rd.tx);
          res.tangent_out_y = FieldW'(rd.ty);
          res.tangent_out_z = FieldW'(rd.tz);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      settle_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q  <= count_d;
      settle_q <= ctrl.insert;
      if (in_acc) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      out_word_q <= res;
    end
  end

  assign in_i.ready = !settle_q && (!out_valid_q || out_o.ready);
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_word_q;

  // occupied cells always match the key count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_vec) == int'(count_q))
    else $error("cell occupancy differs from key count");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.insert |=> count_q == $past(count_q) + 1'b1)
    else $error("insert did not grow the table by one");

  // no command is taken while the tangents settle after an insert
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.insert |=> !in_i.ready)
    else $error("command taken while tangents settle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MaxKeys))
    else $error("key count beyond table size");

endmodule

`default_nettype wire

>>> hdl/crk_cell.sv
`default_nettype none

module crk_cell import crk_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  ctrl_t ctrl_i,
  input  cell_t prev_i,
  input  cell_t next_i,
  output cell_t cell_o
);

  logic                    valid_q, valid_d;
  logic signed [TimeW-1:0] time_q, time_d;
  logic signed [ValW-1:0]  x_q, x_d, y_q, y_d, z_q, z_d;
  logic signed [ValW-1:0]  tx_q, tx_d, ty_q, ty_d, tz_q, tz_d;
  logic signed [ValW-1:0]  nx, ny, nz, px, py, pz;
  logic                    go;

  // key stays put when its time is not after the new one
  assign go = valid_q && (time_q <= ctrl_i.key_time);

  always_comb begin
    valid_d = valid_q;
    time_d  = time_q;
    x_d     = x_q;
    y_d     = y_q;
    z_d     = z_q;
    if (ctrl_i.clear) begin
      valid_d = 1'b0;
    end else if (ctrl_i.insert && !go) begin
      if (prev_i.go) begin
        valid_d = 1'b1;
        time_d  = ctrl_i.key_time;
        x_d     = ctrl_i.x;
        y_d     = ctrl_i.y;
        z_d     = ctrl_i.z;
      end else begin
        valid_d = prev_i.valid;
        time_d  = prev_i.key_time;
        x_d     = prev_i.x;
        y_d     = prev_i.y;
        z_d     = prev_i.z;
      end
    end
  end

  // neighbors clamp to the cell itself at the ends
  always_comb begin
    nx   = next_i.valid ? next_i.x : x_q;
    ny   = next_i.valid ? next_i.y : y_q;
    nz   = next_i.valid ? next_i.z : z_q;
    px   = prev_i.valid ? prev_i.x : x_q;
    py   = prev_i.valid ? prev_i.y : y_q;
    pz   = prev_i.valid ? prev_i.z : z_q;
    tx_d = half_diff(nx, px);
    ty_d = half_diff(ny, py);
    tz_d = half_diff(nz, pz);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    time_q <= time_d;
    x_q    <= x_d;
    y_q    <= y_d;
    z_q    <= z_d;
    tx_q   <= tx_d;
    ty_q   <= ty_d;
    tz_q   <= tz_d;
  end

  assign cell_o.valid    = valid_q;
  assign cell_o.go       = go;
  assign cell_o.key_time = time_q;
  assign cell_o.x        = x_q;
  assign cell_o.y        = y_q;
  assign cell_o.z        = z_q;
  assign cell_o.tx       = tx_q;
  assign cell_o.ty       = ty_q;
  assign cell_o.tz       = tz_q;

endmodule

`default_nettype wire

>>> tb/sv/crk_table_checker.sv
module crk_table_checker import crk_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  crk_in_if    cmd_i,
  crk_out_if   res_i,
  output int   fail_count_o,
  output int   pending_o
);

  logic signed [TimeW-1:0] key_times [MaxKeys];
  logic signed [ValW-1:0]  key_x     [MaxKeys];
  logic signed [ValW-1:0]  key_y     [MaxKeys];
  logic signed [ValW-1:0]  key_z     [MaxKeys];
  int                      held;
  int                      errors = 0;
  out_word_t               expected_results [$];

  assign fail_count_o = errors;

  // floor of half the neighbor difference, wide enough never to wrap
  function automatic logic signed [ValW-1:0] half_slope(
    input logic signed [ValW-1:0] next_v,
    input logic signed [ValW-1:0] prev_v
  );
    longint diff;
    diff = (longint'(next_v) - longint'(prev_v)) >>> 1;
    return diff[ValW-1:0];
  endfunction

  function automatic out_word_t apply_command(input in_word_t w);
    out_word_t r;
    int        slot;
    int        idx;
    int        prv;
    int        nxt;
    r = '0;
    case (w.kind)
      KIND_INSERT: begin
        if (held >= MaxKeys) begin
          r.status = ST_FULL;
        end else begin
          slot = 0;
          while (slot < held && $signed(key_times[slot]) <= $signed(w.key_time)) slot++;
          for (int i = held; i > slot; i--) begin
            key_times[i] = key_times[i-1];
            key_x[i]     = key_x[i-1];
            key_y[i]     = key_y[i-1];
            key_z[i]     = key_z[i-1];
          end
          key_times[slot] = w.key_time;
          key_x[slot]     = w.value_x;
          key_y[slot]     = w.value_y;
          key_z[slot]     = w.value_z;
          held++;
          r.status   = ST_OK;
          r.position = slot[IdxW-1:0];
        end
      end
      KIND_READ: begin
        idx        = int'(w.read_index);
        r.position = w.read_index;
        if (idx >= held) begin
          r.status = ST_RANGE;
        end else begin
          prv             = (idx > 0) ? idx - 1 : idx;
          nxt             = (idx + 1 < held) ? idx + 1 : idx;
          r.status        = ST_OK;
          r.out_time      = key_times[idx];
          r.out_x         = key_x[idx];
          r.out_y         = key_y[idx];
          r.out_z         = key_z[idx];
          r.tangent_out_x = half_slope(key_x[nxt], key_x[prv]);
          r.tangent_out_y = half_slope(key_y[nxt], key_y[prv]);
          r.tangent_out_z = half_slope(key_z[nxt], key_z[prv]);
        end
      end
      KIND_CLEAR: begin
        held = 0;
      end
      default: begin
      end
    endcase
    r.key_count = held[CntW-1:0];
    return r;
  endfunction

  task automatic check_field(input string field, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
    end
  endtask

  task automatic compare_word(input out_word_t want, input out_word_t got);
    check_field("status", 32'(want.status), 32'(got.status));
    check_field("position", 32'(want.position), 32'(got.position));
    check_field("out_time", want.out_time, got.out_time);
    check_field("out_x", want.out_x, got.out_x);
    check_field("out_y", want.out_y, got.out_y);
    check_field("out_z", want.out_z, got.out_z);
    check_field("tangent_out_x", want.tangent_out_x, got.tangent_out_x);
    check_field("tangent_out_y", want.tangent_out_y, got.tangent_out_y);
    check_field("tangent_out_z", want.tangent_out_z, got.tangent_out_z);
    check_field("key_count", 32'(want.key_count), 32'(got.key_count));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held = 0;
      expected_results.delete();
      pending_o <= 0;
    end else begin
      if (res_i.valid && res_i.ready) begin
        if (expected_results.size() == 0) begin
          errors++;
          $display("%0t: result word with none expected, expected nothing, actual %h",
                   $time, res_i.data);
        end else begin
          compare_word(expected_results.pop_front(), res_i.data);
        end
      end
      if (cmd_i.valid && cmd_i.ready) begin
        expected_results.insert(expected_results.size(), apply_command(cmd_i.data));
      end
      pending_o <= expected_results.size();
    end
  end

endmodule

>>> tb/sv/catmull_rom_key_table_tb.sv
module catmull_rom_key_table_tb;
  import crk_pkg::*;

  localparam kind_e KindSpare   = kind_e'(2'd3);
  localparam int    RandomItems = 800;
  localparam int    PhaseLength = 50;
  localparam int    StallLimit  = 5000;
  localparam logic [31:0] MaxWord = 32'h7FFF_FFFF;
  localparam logic [31:0] MinWord = 32'h8000_0000;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  int   tx_idle_pct  = 0;
  int   rx_stall_pct = 0;
  int   sent  = 0;
  int   fill  = 0;
  int   quiet = 0;
  int   fail_count;
  int   pending;
  int   goal;
  int   stop_at;

  crk_in_if  in_if ();
  crk_out_if out_if ();

  catmull_rom_key_table dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  crk_table_checker table_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (in_if),
    .res_i        (out_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    out_if.ready <= ($urandom_range(99) >= rx_stall_pct);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet >= StallLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic logic [31:0] corner_value();
    case ($urandom_range(3))
      0: return MinWord;
      1: return MaxWord;
      2: return 32'h0;
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  function automatic logic [31:0] pick_value();
    if ($urandom_range(3) == 0) return corner_value();
    return $urandom;
  endfunction

  // small spread of times so that equal times happen often
  function automatic logic [31:0] pick_time();
    case ($urandom_range(2))
      0: return ($urandom_range(4) - 2) << 16;
      1: return $urandom;
      default: return corner_value();
    endcase
  endfunction

  function automatic logic [5:0] pick_index();
    if (fill > 0 && $urandom_range(4) != 0) return 6'($urandom_range(fill - 1));
    return 6'($urandom_range(63));
  endfunction

  function automatic in_word_t noisy_word(input kind_e k);
    in_word_t w;
    w.kind       = k;
    w.key_time   = $urandom;
    w.value_x    = $urandom;
    w.value_y    = $urandom;
    w.value_z    = $urandom;
    w.read_index = 6'($urandom_range(63));
    return w;
  endfunction

  task automatic send_word(input in_word_t w);
    case ((sent / PhaseLength) % 4)
      0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
      1: begin tx_idle_pct = 82; rx_stall_pct = 0;  end
      2: begin tx_idle_pct = 0;  rx_stall_pct = 82; end
      default: begin tx_idle_pct = 6; rx_stall_pct = 6; end
    endcase
    while ($urandom_range(99) < tx_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= w;
    do @(posedge clk_i); while (!in_if.ready);
    sent++;
  endtask

  task automatic insert_key(input logic [31:0] t, input logic [31:0] x,
                            input logic [31:0] y, input logic [31:0] z);
    in_word_t w;
    w          = noisy_word(KIND_INSERT);
    w.key_time = t;
    w.value_x  = x;
    w.value_y  = y;
    w.value_z  = z;
    send_word(w);
    if (fill < MaxKeys) fill++;
  endtask

  task automatic read_entry(input logic [5:0] idx);
    in_word_t w;
    w            = noisy_word(KIND_READ);
    w.read_index = idx;
    send_word(w);
  endtask

  task automatic send_plain(input kind_e k);
    send_word(noisy_word(k));
    if (k == KIND_CLEAR) fill = 0;
  endtask

  initial begin
    in_if.valid  = 1'b0;
    in_if.data   = '0;
    out_if.ready = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty table, unused kind, extreme times and values, equal times
    read_entry(6'd0);
    send_plain(KIND_CLEAR);
    send_plain(KindSpare);
    insert_key(MaxWord, MaxWord, MaxWord, MaxWord);
    read_entry(6'd0);
    insert_key(MinWord, MinWord, MinWord, MinWord);
    insert_key(MaxWord, 32'h0, 32'hFFFF_FFFF, 32'h1);
    insert_key(32'h0, 32'h3, 32'hFFFF_FFFD, 32'h0001_8000);
    for (int i = 0; i < 4; i++) read_entry(6'(i));
    read_entry(6'd4);
    read_entry(6'd63);
    insert_key(32'h0001_0000, 32'hFFFF_FFFB, 32'h7, MinWord);
    for (int i = 0; i < 5; i++) read_entry(6'(i));
    send_plain(KindSpare);
    send_plain(KIND_CLEAR);
    read_entry(6'd0);

    stop_at = sent + RandomItems;
    while (sent < stop_at) begin
      goal = ($urandom_range(4) == 0) ? MaxKeys + $urandom_range(1, 6) : $urandom_range(1, 20);
      for (int n = 0; n < goal; n++) begin
        insert_key(pick_time(), pick_value(), pick_value(), pick_value());
        if ($urandom_range(9) < 3) read_entry(pick_index());
      end
      repeat ($urandom_range(1, 4)) read_entry(pick_index());
      case ($urandom_range(9))
        0: send_plain(KindSpare);
        1: read_entry(6'($urandom_range(63)));
        2: begin
        end
        default: send_plain(KIND_CLEAR);
      endcase
    end

    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
